@@ rtl/core/assert_macros.svh @@
// assertion macros shared by the direction angle core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PDAD_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("pdad assertion failed");
`define PDAD_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pdad implication failed");
`else
`define PDAD_ASSERT(lbl, clk, rst_n, prop)
`define PDAD_IMPLY(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/core/pdad_pkg.sv @@
// types, constants and the arctangent table of the direction angle core
package pdad_pkg;

	localparam int COORD_BITS   = 24;
	localparam int CORDIC_STEPS = 24;
	localparam int GUARD        = 8;
	localparam int TABLE_LEN    = 32;
	localparam int STEP_W       = $clog2(TABLE_LEN);
	localparam int DW           = COORD_BITS + 1;
	localparam int XW           = DW + GUARD + 3;
	localparam int ZW           = 33;
	localparam int ROUND_BITS   = 8;
	localparam int RW           = ZW - ROUND_BITS;
	localparam int ANGLE_W      = 25;
	localparam int DEG          = 65536;

	localparam logic [ANGLE_W-1:0] ANG_0   = ANGLE_W'(0);
	localparam logic [ANGLE_W-1:0] ANG_90  = ANGLE_W'(90 * DEG);
	localparam logic [ANGLE_W-1:0] ANG_180 = ANGLE_W'(180 * DEG);
	localparam logic [ANGLE_W-1:0] ANG_270 = ANGLE_W'(270 * DEG);
	localparam logic [ANGLE_W-1:0] ANG_360 = ANGLE_W'(360 * DEG);

	typedef enum logic [1:0] {
		QUAD_I,
		QUAD_II,
		QUAD_III,
		QUAD_IV
	} quad_t;

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
	} cordic_t;

	typedef struct packed {
		logic                special;
		logic [ANGLE_W-1:0]  fixed_angle;
		quad_t               quad;
	} tag_t;

	// atan(2^-i) in 1/2^24 degree, rounded to nearest
	function automatic logic [ZW-1:0] atan_entry(logic [STEP_W-1:0] i);
		case (i)
			5'd0:    atan_entry = ZW'(754974720);
			5'd1:    atan_entry = ZW'(445687602);
			5'd2:    atan_entry = ZW'(235489088);
			5'd3:    atan_entry = ZW'(119537938);
			5'd4:    atan_entry = ZW'(60000934);
			5'd5:    atan_entry = ZW'(30029717);
			5'd6:    atan_entry = ZW'(15018523);
			5'd7:    atan_entry = ZW'(7509720);
			5'd8:    atan_entry = ZW'(3754917);
			5'd9:    atan_entry = ZW'(1877466);
			5'd10:   atan_entry = ZW'(938734);
			5'd11:   atan_entry = ZW'(469367);
			5'd12:   atan_entry = ZW'(234684);
			5'd13:   atan_entry = ZW'(117342);
			5'd14:   atan_entry = ZW'(58671);
			5'd15:   atan_entry = ZW'(29335);
			5'd16:   atan_entry = ZW'(14668);
			5'd17:   atan_entry = ZW'(7334);
			5'd18:   atan_entry = ZW'(3667);
			5'd19:   atan_entry = ZW'(1833);
			5'd20:   atan_entry = ZW'(917);
			5'd21:   atan_entry = ZW'(458);
			5'd22:   atan_entry = ZW'(229);
			5'd23:   atan_entry = ZW'(115);
			5'd24:   atan_entry = ZW'(57);
			5'd25:   atan_entry = ZW'(29);
			5'd26:   atan_entry = ZW'(14);
			5'd27:   atan_entry = ZW'(7);
			5'd28:   atan_entry = ZW'(4);
			5'd29:   atan_entry = ZW'(2);
			5'd30:   atan_entry = ZW'(1);
			default: atan_entry = ZW'(0);
		endcase
	endfunction

endpackage

@@ rtl/core/pdad_prep.sv @@
// input stage: coordinate differences, magnitudes, quadrant and special cases
module pdad_prep (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [pdad_pkg::COORD_BITS-1:0]       from_x,
	input  logic [pdad_pkg::COORD_BITS-1:0]       from_y,
	input  logic [pdad_pkg::COORD_BITS-1:0]       to_x,
	input  logic [pdad_pkg::COORD_BITS-1:0]       to_y,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output pdad_pkg::cordic_t                     out_data,
	output pdad_pkg::tag_t                        out_tag
);

	logic [pdad_pkg::DW-1:0] dx;
	logic [pdad_pkg::DW-1:0] dy;
	logic [pdad_pkg::DW-1:0] ax;
	logic [pdad_pkg::DW-1:0] ay;
	logic                    dx_zero;
	logic                    dy_zero;
	logic                    dx_neg;
	logic                    dy_neg;
	pdad_pkg::cordic_t       data_d;
	pdad_pkg::tag_t          tag_d;
	logic                    valid_q;
	logic                    accept;

	assign dx = {to_x[pdad_pkg::COORD_BITS-1], to_x} - {from_x[pdad_pkg::COORD_BITS-1], from_x};
	assign dy = {to_y[pdad_pkg::COORD_BITS-1], to_y} - {from_y[pdad_pkg::COORD_BITS-1], from_y};
	assign dx_neg  = dx[pdad_pkg::DW-1];
	assign dy_neg  = dy[pdad_pkg::DW-1];
	assign dx_zero = (dx == '0);
	assign dy_zero = (dy == '0);
	assign ax = dx_neg ? (~dx + pdad_pkg::DW'(1)) : dx;
	assign ay = dy_neg ? (~dy + pdad_pkg::DW'(1)) : dy;

	always_comb begin
		data_d.x = {{(pdad_pkg::XW - pdad_pkg::DW - pdad_pkg::GUARD){1'b0}}, ax,
			{pdad_pkg::GUARD{1'b0}}};
		data_d.y = {{(pdad_pkg::XW - pdad_pkg::DW - pdad_pkg::GUARD){1'b0}}, ay,
			{pdad_pkg::GUARD{1'b0}}};
		data_d.z = '0;

		tag_d.special     = dx_zero || dy_zero;
		tag_d.fixed_angle = pdad_pkg::ANG_0;
		// vertical wins over horizontal, coincident points land on 270
		if (dx_zero) begin
			tag_d.fixed_angle = (!dy_neg && !dy_zero) ? pdad_pkg::ANG_90 : pdad_pkg::ANG_270;
		end else if (dy_zero) begin
			tag_d.fixed_angle = dx_neg ? pdad_pkg::ANG_180 : pdad_pkg::ANG_0;
		end
		case ({dx_neg, dy_neg})
			2'b00:   tag_d.quad = pdad_pkg::QUAD_I;
			2'b10:   tag_d.quad = pdad_pkg::QUAD_II;
			2'b11:   tag_d.quad = pdad_pkg::QUAD_III;
			default: tag_d.quad = pdad_pkg::QUAD_IV;
		endcase
	end

	assign in_ready  = !valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data <= data_d;
			out_tag  <= tag_d;
		end
	end

endmodule

@@ rtl/core/pdad_cell.sv @@
// one cordic vectoring micro-rotation with its own pipeline register
module pdad_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [pdad_pkg::STEP_W-1:0]       step,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  pdad_pkg::cordic_t                 in_data,
	input  pdad_pkg::tag_t                    in_tag,
	output logic                              out_valid,
	input  logic                              out_ready,
	output pdad_pkg::cordic_t                 out_data,
	output pdad_pkg::tag_t                    out_tag
);

	logic signed [pdad_pkg::XW-1:0] xs;
	logic signed [pdad_pkg::XW-1:0] ys;
	logic signed [pdad_pkg::ZW-1:0] t;
	pdad_pkg::cordic_t              data_d;
	logic                           valid_q;
	logic                           accept;

	// arithmetic shift gives the floor of the division
	assign xs = $signed(in_data.x) >>> step;
	assign ys = $signed(in_data.y) >>> step;
	assign t  = $signed(pdad_pkg::atan_entry(step));

	always_comb begin
		if (!in_data.y[pdad_pkg::XW-1]) begin
			data_d.x = $signed(in_data.x) + ys;
			data_d.y = $signed(in_data.y) - xs;
			data_d.z = $signed(in_data.z) + t;
		end else begin
			data_d.x = $signed(in_data.x) - ys;
			data_d.y = $signed(in_data.y) + xs;
			data_d.z = $signed(in_data.z) - t;
		end
	end

	assign in_ready  = !valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data <= data_d;
			out_tag  <= in_tag;
		end
	end

endmodule

@@ rtl/core/pdad_post.sv @@
// output stage: rounding, clamp, quadrant mapping, special-case angles, full-turn wrap and the output register
module pdad_post (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  pdad_pkg::cordic_t                 in_data,
	input  pdad_pkg::tag_t                    in_tag,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [pdad_pkg::ANGLE_W-1:0]      angle
);

	logic [pdad_pkg::ZW-1:0]      z_pos;
	logic [pdad_pkg::ZW-1:0]      z_rnd;
	logic [pdad_pkg::RW-1:0]      a_full;
	logic [pdad_pkg::ANGLE_W-1:0] a;
	logic [pdad_pkg::ANGLE_W-1:0] r;
	logic [pdad_pkg::ANGLE_W-1:0] angle_d;
	logic                         valid_q;
	logic                         accept;

	assign z_pos  = in_data.z[pdad_pkg::ZW-1] ? '0 : in_data.z;
	assign z_rnd  = z_pos + pdad_pkg::ZW'(1 << (pdad_pkg::ROUND_BITS - 1));
	assign a_full = z_rnd[pdad_pkg::ZW-1:pdad_pkg::ROUND_BITS];
	assign a      = (a_full > pdad_pkg::RW'(pdad_pkg::ANG_90)) ? pdad_pkg::ANG_90
		: pdad_pkg::ANGLE_W'(a_full);

	always_comb begin
		unique case (in_tag.quad)
			pdad_pkg::QUAD_I:   r = a;
			pdad_pkg::QUAD_II:  r = pdad_pkg::ANG_180 - a;
			pdad_pkg::QUAD_III: r = pdad_pkg::ANG_180 + a;
			pdad_pkg::QUAD_IV:  r = pdad_pkg::ANG_360 - a;
			default:            r = a;
		endcase
		if (in_tag.special) begin
			angle_d = in_tag.fixed_angle;
		end else if (r >= pdad_pkg::ANG_360) begin
			// a full turn wraps to zero
			angle_d = pdad_pkg::ANG_0;
		end else begin
			angle_d = r;
		end
	end

	assign in_ready  = !valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			angle <= angle_d;
		end
	end

endmodule

@@ rtl/core/point_direction_angle_degrees_core.sv @@
// an item passes the prep, cell and output registers in turn
// throughput: one item per cycle if not stalled; a cell per micro-rotation
// each stage holds its item only while the next stage is full and stalled
// reset clears the stage valid bits only; datapath registers are not reset
// top level of the point direction angle core
`include "assert_macros.svh"
module point_direction_angle_degrees_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [pdad_pkg::COORD_BITS-1:0]   from_x,
	input  logic [pdad_pkg::COORD_BITS-1:0]   from_y,
	input  logic [pdad_pkg::COORD_BITS-1:0]   to_x,
	input  logic [pdad_pkg::COORD_BITS-1:0]   to_y,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [pdad_pkg::ANGLE_W-1:0]      angle
);

	logic              stage_valid [0:pdad_pkg::CORDIC_STEPS];
	logic              stage_ready [0:pdad_pkg::CORDIC_STEPS];
	pdad_pkg::cordic_t stage_data  [0:pdad_pkg::CORDIC_STEPS];
	pdad_pkg::tag_t    stage_tag   [0:pdad_pkg::CORDIC_STEPS];

	pdad_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.from_x    (from_x),
		.from_y    (from_y),
		.to_x      (to_x),
		.to_y      (to_y),
		.out_valid (stage_valid[0]),
		.out_ready (stage_ready[0]),
		.out_data  (stage_data[0]),
		.out_tag   (stage_tag[0])
	);

	for (genvar g = 0; g < pdad_pkg::CORDIC_STEPS; g++) begin : g_cell
		pdad_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.step      (pdad_pkg::STEP_W'(g)),
			.in_valid  (stage_valid[g]),
			.in_ready  (stage_ready[g]),
			.in_data   (stage_data[g]),
			.in_tag    (stage_tag[g]),
			.out_valid (stage_valid[g+1]),
			.out_ready (stage_ready[g+1]),
			.out_data  (stage_data[g+1]),
			.out_tag   (stage_tag[g+1])
		);
	end

	pdad_post u_post (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (stage_valid[pdad_pkg::CORDIC_STEPS]),
		.in_ready  (stage_ready[pdad_pkg::CORDIC_STEPS]),
		.in_data   (stage_data[pdad_pkg::CORDIC_STEPS]),
		.in_tag    (stage_tag[pdad_pkg::CORDIC_STEPS]),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.angle     (angle)
	);

	`PDAD_ASSERT(a_angle_range, clk, arst_n, !out_valid || (angle < pdad_pkg::ANG_360))
	`PDAD_IMPLY(a_stall_only_when_full, clk, arst_n, !in_ready, out_valid && !out_ready)
	`PDAD_ASSERT(a_accept_fills_prep, clk, arst_n, in_valid && in_ready |=> stage_valid[0])
	`PDAD_IMPLY(a_last_cell_moves, clk, arst_n, stage_valid[pdad_pkg::CORDIC_STEPS] && !out_valid, stage_ready[pdad_pkg::CORDIC_STEPS])

endmodule
